@@ design/plst_pkg.sv @@
// Shared constants, codes and types of the positional list engine.
`default_nettype none

package plst_pkg;

   localparam int CAPACITY   = 16;
   localparam int DUMP_LIMIT = 16;

   localparam int KIND_BITS  = 3;
   localparam int POS_BITS   = 5;
   localparam int VALUE_BITS = 32;
   localparam int STAT_BITS  = 2;
   localparam int CNT_BITS   = 5;

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int INDEX_BITS = $clog2(CAPACITY);
   localparam int CMP_BITS   = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS;

   localparam int REQ_DATA_BITS = ((POS_BITS + VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((STAT_BITS + CNT_BITS + VALUE_BITS + 7) / 8) * 8;

   localparam logic [KIND_BITS-1:0] KIND_INS_HEAD = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_INS_TAIL = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_INS_POS  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_DEL_POS  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_DUMP_FWD = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_DUMP_REV = 3'd5;

   localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_BITS-1:0] STAT_EMPTY     = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic latch_cmd;
      logic apply_op;
      logic clear_idx;
      logic load_dump;
   } dp_cmd_type;

   typedef struct packed {
      logic is_dump;
      logic list_empty;
      logic dump_last;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

@@ design/plst_ctrl.sv @@
// Controller state machine of the positional list engine.
`default_nettype none

module plst_ctrl
   import plst_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  dp_sts_type      dp_sts,
   output dp_cmd_type      dp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (dp_sts.out_free) begin
               if (dp_sts.is_dump && !dp_sts.list_empty) begin
                  state_in = ST_DUMP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DUMP: begin
            if (dp_sts.out_free && dp_sts.dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      dp_cmd     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready       = 1'b1;
            dp_cmd.latch_cmd = req_tvalid;
         end
         ST_EXEC: begin
            if (dp_sts.out_free) begin
               if (dp_sts.is_dump && !dp_sts.list_empty) begin
                  dp_cmd.clear_idx = 1'b1;
               end else begin
                  dp_cmd.apply_op = 1'b1;
               end
            end
         end
         ST_DUMP: begin
            dp_cmd.load_dump = dp_sts.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> !dp_sts.list_empty)
      else $error("Dump in progress on an empty list.");

   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.apply_op || dp_cmd.load_dump) |-> dp_sts.out_free)
      else $error("Result loaded while the output register is occupied.");

endmodule

`default_nettype wire

@@ design/plst_dp.sv @@
// Datapath of the positional list engine: element cells, count, command and result registers.
`default_nettype none

module plst_dp
   import plst_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  dp_cmd_type                    dp_cmd,
   output dp_sts_type                    dp_sts,
   input  wire logic [KIND_BITS-1:0]     req_kind,
   input  wire logic [POS_BITS-1:0]      req_position,
   input  wire logic [VALUE_BITS-1:0]    req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [STAT_BITS-1:0]          rsp_status,
   output logic [CNT_BITS-1:0]           rsp_count,
   output logic [VALUE_BITS-1:0]         rsp_value,
   output logic                          rsp_last
);

   logic [KIND_BITS-1:0]  cmd_kind_ff;
   logic [POS_BITS-1:0]   cmd_pos_ff;
   logic [VALUE_BITS-1:0] cmd_value_ff;

   logic [VALUE_BITS-1:0] cell_ff [CAPACITY];
   logic [VALUE_BITS-1:0] cell_in [CAPACITY];
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [INDEX_BITS-1:0] idx_ff;
   logic [INDEX_BITS-1:0] idx_in;

   logic                  out_valid_ff;
   logic [STAT_BITS-1:0]  out_status_ff;
   logic [CNT_BITS-1:0]   out_count_ff;
   logic [VALUE_BITS-1:0] out_value_ff;
   logic                  out_last_ff;

   logic                  is_ins;
   logic                  is_del;
   logic                  is_dump;
   logic                  list_full;
   logic                  list_empty;
   logic [CMP_BITS-1:0]   pos_ext;
   logic [CMP_BITS-1:0]   count_ext;
   logic [CMP_BITS-1:0]   ins_pos;
   logic                  ins_bad;
   logic                  del_bad;
   logic                  ins_go;
   logic                  del_go;
   logic [STAT_BITS-1:0]  op_status;
   logic [COUNT_BITS-1:0] dump_n;
   logic [COUNT_BITS-1:0] rd_count;
   logic [INDEX_BITS-1:0] rd_idx;
   logic                  dump_last;
   logic                  out_free;

   always_ff @(posedge clock) begin
      if (dp_cmd.latch_cmd) begin
         cmd_kind_ff  <= req_kind;
         cmd_pos_ff   <= req_position;
         cmd_value_ff <= req_value;
      end
   end

   assign is_ins     = (cmd_kind_ff == KIND_INS_HEAD) || (cmd_kind_ff == KIND_INS_TAIL)
                    || (cmd_kind_ff == KIND_INS_POS);
   assign is_del     = (cmd_kind_ff == KIND_DEL_POS);
   assign is_dump    = (cmd_kind_ff == KIND_DUMP_FWD) || (cmd_kind_ff == KIND_DUMP_REV);
   assign list_full  = (count_ff == COUNT_BITS'(CAPACITY));
   assign list_empty = (count_ff == '0);
   assign pos_ext    = CMP_BITS'(cmd_pos_ff);
   assign count_ext  = CMP_BITS'(count_ff);

   always_comb begin
      unique case (cmd_kind_ff)
         KIND_INS_HEAD: ins_pos = '0;
         KIND_INS_TAIL: ins_pos = count_ext;
         default:       ins_pos = pos_ext;
      endcase
   end

   assign ins_bad = (ins_pos > count_ext);
   assign del_bad = (pos_ext >= count_ext);
   assign ins_go  = dp_cmd.apply_op && is_ins && !list_full && !ins_bad;
   assign del_go  = dp_cmd.apply_op && is_del && !list_empty && !del_bad;

   always_comb begin
      op_status = STAT_OK;
      if (is_ins) begin
         if (list_full) begin
            op_status = STAT_FULL;
         end else if (ins_bad) begin
            op_status = STAT_BAD_INDEX;
         end
      end else if (is_del) begin
         if (list_empty) begin
            op_status = STAT_EMPTY;
         end else if (del_bad) begin
            op_status = STAT_BAD_INDEX;
         end
      end else if (is_dump && list_empty) begin
         op_status = STAT_EMPTY;
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (ins_go) begin
         if (ins_pos == '0) begin
            cell_in[0] = cmd_value_ff;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (CMP_BITS'(i) == ins_pos) begin
               cell_in[i] = cmd_value_ff;
            end else if (CMP_BITS'(i) > ins_pos) begin
               cell_in[i] = cell_ff[i-1];
            end
         end
      end else if (del_go) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (CMP_BITS'(i) >= pos_ext) begin
               cell_in[i] = cell_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ins_go) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (del_go) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   assign dump_n    = (count_ff < COUNT_BITS'(DUMP_LIMIT)) ? count_ff
                                                           : COUNT_BITS'(DUMP_LIMIT);
   assign dump_last = ((COUNT_BITS'(idx_ff) + COUNT_BITS'(1)) == dump_n);
   assign rd_count  = (cmd_kind_ff == KIND_DUMP_REV)
                    ? (count_ff - COUNT_BITS'(1) - COUNT_BITS'(idx_ff))
                    : COUNT_BITS'(idx_ff);
   assign rd_idx    = rd_count[INDEX_BITS-1:0];

   always_comb begin
      idx_in = idx_ff;
      if (dp_cmd.clear_idx) begin
         idx_in = '0;
      end else if (dp_cmd.load_dump) begin
         idx_in = idx_ff + INDEX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (dp_cmd.apply_op || dp_cmd.load_dump) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.apply_op) begin
         out_status_ff <= op_status;
         out_count_ff  <= CNT_BITS'(count_in);
         out_value_ff  <= '0;
         out_last_ff   <= 1'b1;
      end else if (dp_cmd.load_dump) begin
         out_status_ff <= STAT_OK;
         out_count_ff  <= CNT_BITS'(count_ff);
         out_value_ff  <= cell_ff[rd_idx];
         out_last_ff   <= dump_last;
      end
   end

   assign dp_sts.is_dump    = is_dump;
   assign dp_sts.list_empty = list_empty;
   assign dp_sts.dump_last  = dump_last;
   assign dp_sts.out_free   = out_free;

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_count  = out_count_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_last   = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("Element count exceeds capacity.");

   assert property (@(posedge clock) disable iff (reset)
      ins_go |=> (count_ff == $past(count_ff) + COUNT_BITS'(1)))
      else $error("Successful insert did not grow the list by one.");

   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.apply_op || dp_cmd.load_dump) |=> out_valid_ff)
      else $error("Loaded result is not presented.");

endmodule

`default_nettype wire

@@ design/positional_list_engine_core.sv @@
// Top level of the positional list engine: controller and datapath with stream ports.
//
// An ordered list of up to 16 signed 32-bit values kept packed in register cells.
// Each request transfer carries one command: insert at head, tail or position, delete at a
// position, or dump forward or reverse. Insert, delete and unused kinds take the command in the
// idle state, then shift all cells at once and load the result register in the execute state,
// and give one response transfer with tlast set. A dump of n elements gives n response
// transfers, one element per cycle from the single result register when the output is free;
// a dump of an empty list gives one response with the empty status. Response back-pressure
// stalls the engine, but the next request is taken while a finished result still waits.
`default_nettype none

module positional_list_engine_core
   import plst_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,  // position, value, zero fill
   input  wire logic [KIND_BITS-1:0]     req_tuser,  // kind
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,  // status, element_count, element_value, zero fill
   output logic                          rsp_tlast
);

   dp_cmd_type            dp_cmd;
   dp_sts_type            dp_sts;
   logic [STAT_BITS-1:0]  rsp_status;
   logic [CNT_BITS-1:0]   rsp_count;
   logic [VALUE_BITS-1:0] rsp_value;

   plst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_sts     (dp_sts),
      .dp_cmd     (dp_cmd)
   );

   plst_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .dp_cmd       (dp_cmd),
      .dp_sts       (dp_sts),
      .req_kind     (req_tuser),
      .req_position (req_tdata[POS_BITS-1:0]),
      .req_value    (req_tdata[POS_BITS+VALUE_BITS-1:POS_BITS]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_BITS'({rsp_value, rsp_count, rsp_status});

endmodule

`default_nettype wire
